FILE: src/mmed_pkg.sv
// shared types and constants for the min/max envelope decimator
// no dependencies
`timescale 1ns / 1ps

package mmed_pkg;

    localparam int MAX_COLUMNS    = 2048;
    localparam int COL_BITS       = 11;
    localparam int COLS_BITS      = 12;
    localparam int SAMPLE_BITS    = 16;
    localparam int HIGH_BITS      = 15;
    localparam int COUNT_BITS     = 32;
    localparam int PROD_BITS      = COUNT_BITS + COLS_BITS;
    localparam int STEP_BITS      = 4;
    localparam int CFG_INDEX_BITS = 1;
    localparam int WORD_BITS      = SAMPLE_BITS + HIGH_BITS;

    localparam logic [CFG_INDEX_BITS-1:0] REG_TOTAL_FRAMES = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COLUMN_COUNT = 1'b1;

    localparam logic [COUNT_BITS-1:0] TOTAL_FRAMES_RESET = 32'd1;
    localparam logic [COLS_BITS-1:0]  COLUMN_COUNT_RESET = 12'd1024;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_READ,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        logic clr;
        logic take;
        logic mul;
        logic div;
        logic read;
        logic update;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic div_last;
        logic past;
        logic out_busy;
    } status_t;

endpackage

FILE: src/mmed_ctrl.sv
// sequencer for the min/max envelope decimator
// depends on mmed_pkg
`timescale 1ns / 1ps

module mmed_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  mmed_pkg::status_t status,
    output mmed_pkg::cmd_t    cmd
);

    mmed_pkg::state_t state_reg;
    mmed_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mmed_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            mmed_pkg::ST_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (status.clr_last)
                begin
                    state_next = mmed_pkg::ST_IDLE;
                end
            end
            mmed_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = mmed_pkg::ST_MUL;
                end
            end
            mmed_pkg::ST_MUL:
            begin
                cmd.mul = 1'b1;
                if (status.past)
                begin
                    state_next = mmed_pkg::ST_READ;
                end
                else
                begin
                    state_next = mmed_pkg::ST_DIV;
                end
            end
            mmed_pkg::ST_DIV:
            begin
                cmd.div = 1'b1;
                if (status.div_last)
                begin
                    state_next = mmed_pkg::ST_READ;
                end
            end
            mmed_pkg::ST_READ:
            begin
                cmd.read   = 1'b1;
                state_next = mmed_pkg::ST_UPDATE;
            end
            mmed_pkg::ST_UPDATE:
            begin
                if (!status.out_busy)
                begin
                    cmd.update = 1'b1;
                    state_next = mmed_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mmed_pkg::ST_CLEAR;
            end
        endcase
    end

endmodule

FILE: src/mmed_dp.sv
// datapath: config registers, sample index, column divider, min/max store, output register
// depends on mmed_pkg
`timescale 1ns / 1ps

module mmed_dp (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  mmed_pkg::cmd_t                          cmd,
    output mmed_pkg::status_t                       status,
    input  logic                                    cfg_valid,
    input  logic                                    cfg_ready,
    input  logic [mmed_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [mmed_pkg::COUNT_BITS-1:0]         cfg_data,
    input  logic signed [mmed_pkg::SAMPLE_BITS-1:0] sample,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic [mmed_pkg::COL_BITS-1:0]           column,
    output logic signed [mmed_pkg::SAMPLE_BITS-1:0] lowest,
    output logic [mmed_pkg::HIGH_BITS-1:0]          highest,
    output logic                                    past_end
);

    logic [mmed_pkg::COUNT_BITS-1:0]         total_reg;
    logic [mmed_pkg::COLS_BITS-1:0]          ccount_reg;
    logic [mmed_pkg::COUNT_BITS-1:0]         idx_reg;
    logic [mmed_pkg::COLS_BITS-1:0]          eff_cols_reg;
    logic [mmed_pkg::COLS_BITS-1:0]          eff_cols_next;
    logic signed [mmed_pkg::SAMPLE_BITS-1:0] sample_reg;
    logic                                    past_reg;
    logic [mmed_pkg::COL_BITS-1:0]           col_reg;
    logic [mmed_pkg::PROD_BITS-1:0]          rem_reg;
    logic [mmed_pkg::PROD_BITS-1:0]          dvs_reg;
    logic [mmed_pkg::PROD_BITS-1:0]          prod;
    logic [mmed_pkg::STEP_BITS-1:0]          step_reg;
    logic [mmed_pkg::COL_BITS-1:0]           clr_cnt_reg;
    logic [mmed_pkg::WORD_BITS-1:0]          rd_data_reg;
    logic [mmed_pkg::WORD_BITS-1:0]          mem [mmed_pkg::MAX_COLUMNS];
    logic signed [mmed_pkg::SAMPLE_BITS-1:0] old_min;
    logic [mmed_pkg::HIGH_BITS-1:0]          old_max;
    logic signed [mmed_pkg::SAMPLE_BITS-1:0] new_min;
    logic [mmed_pkg::HIGH_BITS-1:0]          new_max;
    logic                                    wr_en;
    logic [mmed_pkg::COL_BITS-1:0]           wr_addr;
    logic [mmed_pkg::WORD_BITS-1:0]          wr_data;
    logic                                    out_valid_reg;
    logic [mmed_pkg::COL_BITS-1:0]           column_reg;
    logic signed [mmed_pkg::SAMPLE_BITS-1:0] lowest_reg;
    logic [mmed_pkg::HIGH_BITS-1:0]          highest_reg;
    logic                                    past_end_reg;

    // column count zero acts as one, above the store depth saturates
    always_comb
    begin
        if (ccount_reg == '0)
        begin
            eff_cols_next = mmed_pkg::COLS_BITS'(1);
        end
        else if (ccount_reg > mmed_pkg::COLS_BITS'(mmed_pkg::MAX_COLUMNS))
        begin
            eff_cols_next = mmed_pkg::COLS_BITS'(mmed_pkg::MAX_COLUMNS);
        end
        else
        begin
            eff_cols_next = ccount_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg  <= mmed_pkg::TOTAL_FRAMES_RESET;
            ccount_reg <= mmed_pkg::COLUMN_COUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                mmed_pkg::REG_TOTAL_FRAMES: total_reg  <= cfg_data;
                mmed_pkg::REG_COLUMN_COUNT: ccount_reg <= cfg_data[mmed_pkg::COLS_BITS-1:0];
                default:                    total_reg  <= total_reg;
            endcase
        end
    end

    assign prod = idx_reg * eff_cols_reg;

    // sample index saturates at all ones
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= '0;
            clr_cnt_reg <= '0;
            step_reg    <= '0;
        end
        else
        begin
            if (cmd.update && (idx_reg != '1))
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.clr)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.mul)
            begin
                step_reg <= mmed_pkg::STEP_BITS'(mmed_pkg::COL_BITS - 1);
            end
            else if (cmd.div)
            begin
                step_reg <= step_reg - 1'b1;
            end
        end
    end

    // restoring divide, one quotient bit per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            sample_reg   <= sample;
            past_reg     <= (idx_reg >= total_reg);
            eff_cols_reg <= eff_cols_next;
            col_reg      <= mmed_pkg::COL_BITS'(eff_cols_next - 1'b1);
        end
        if (cmd.mul)
        begin
            rem_reg <= prod;
            dvs_reg <= mmed_pkg::PROD_BITS'(total_reg) << (mmed_pkg::COL_BITS - 1);
            if (!past_reg)
            begin
                col_reg <= '0;
            end
        end
        if (cmd.div)
        begin
            dvs_reg <= dvs_reg >> 1;
            if (rem_reg >= dvs_reg)
            begin
                rem_reg <= rem_reg - dvs_reg;
                col_reg <= {col_reg[mmed_pkg::COL_BITS-2:0], 1'b1};
            end
            else
            begin
                col_reg <= {col_reg[mmed_pkg::COL_BITS-2:0], 1'b0};
            end
        end
    end

    assign old_min = rd_data_reg[mmed_pkg::WORD_BITS-1:mmed_pkg::HIGH_BITS];
    assign old_max = rd_data_reg[mmed_pkg::HIGH_BITS-1:0];

    always_comb
    begin
        new_min = (sample_reg < old_min) ? sample_reg : old_min;
        if (sample_reg > $signed({1'b0, old_max}))
        begin
            new_max = sample_reg[mmed_pkg::HIGH_BITS-1:0];
        end
        else
        begin
            new_max = old_max;
        end
    end

    assign wr_en   = cmd.clr || cmd.update;
    assign wr_addr = cmd.clr ? clr_cnt_reg : col_reg;
    assign wr_data = cmd.clr ? '0 : {new_min, new_max};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.read)
        begin
            rd_data_reg <= mem[col_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.update)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            column_reg   <= col_reg;
            lowest_reg   <= new_min;
            highest_reg  <= new_max;
            past_end_reg <= past_reg;
        end
    end

    assign status.clr_last = (clr_cnt_reg == mmed_pkg::COL_BITS'(mmed_pkg::MAX_COLUMNS - 1));
    assign status.div_last = (step_reg == '0);
    assign status.past     = past_reg;
    assign status.out_busy = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign column    = column_reg;
    assign lowest    = lowest_reg;
    assign highest   = highest_reg;
    assign past_end  = past_end_reg;

endmodule

FILE: src/min_max_envelope_decimator.sv
// top level of the min/max envelope decimator
// depends on mmed_pkg, mmed_ctrl and mmed_dp
`timescale 1ns / 1ps

// Reduces a stream of signed Q1.15 samples to one min/max pair per display column.
// Each accepted sample is mapped to column floor(index * column_count / total_frames),
// or the last column once the running index reaches total_frames, and that column's
// stored pair is updated and returned with the column and a past-end flag. One sample
// is worked on at a time: the next sample is taken only once the result of the last
// has been written to the output register. The 11-step restoring divider finds the
// column, and is skipped past the end; the read-modify-write of the 2048-entry store
// then updates the pair. A result still waiting in the output register holds the next
// one back until it is taken. After reset a clearing pass zeroes the store, with
// in_ready low throughout. cfg_ready is always high; write registers only while the
// block is idle. A finished result waits in the output register while the next sample
// is taken in.

module min_max_envelope_decimator (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [mmed_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [mmed_pkg::COUNT_BITS-1:0]         cfg_data,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic signed [mmed_pkg::SAMPLE_BITS-1:0] sample,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic [mmed_pkg::COL_BITS-1:0]           column,
    output logic signed [mmed_pkg::SAMPLE_BITS-1:0] lowest,
    output logic [mmed_pkg::HIGH_BITS-1:0]          highest,
    output logic                                    past_end
);

    mmed_pkg::cmd_t    cmd;
    mmed_pkg::status_t status;

    assign cfg_ready = 1'b1;

    mmed_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    mmed_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .column    (column),
        .lowest    (lowest),
        .highest   (highest),
        .past_end  (past_end)
    );

    // stored minimum never rises above zero
    a_lowest_nonpositive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (lowest[mmed_pkg::SAMPLE_BITS-1] || (lowest == '0)))
        else $error("lowest above zero");

    // one sample in flight at a time
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while busy");

    // a result is never written over one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |-> !(out_valid && !out_ready))
        else $error("output register overwritten");

endmodule

FILE: tb/min_max_envelope_decimator_tb.sv
// self-checking testbench for min_max_envelope_decimator: directed default mapping and
// register edge cases, then random takes, all checked against a column min/max
// predictor kept in the bench; depends on mmed_pkg and min_max_envelope_decimator
`timescale 1ns / 1ps

module min_max_envelope_decimator_tb;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int LATENCY     = 16;
    localparam int ITEM_TARGET = 1900;

    typedef struct {
        logic [mmed_pkg::COL_BITS-1:0]           column;
        logic signed [mmed_pkg::SAMPLE_BITS-1:0] lowest;
        logic [mmed_pkg::HIGH_BITS-1:0]          highest;
        logic                                    past_end;
    } envelope_t;

    logic                                    clk;
    logic                                    rst_n;
    logic                                    cfg_valid;
    logic                                    cfg_ready;
    logic [mmed_pkg::CFG_INDEX_BITS-1:0]     cfg_index;
    logic [mmed_pkg::COUNT_BITS-1:0]         cfg_data;
    logic                                    in_valid;
    logic                                    in_ready;
    logic signed [mmed_pkg::SAMPLE_BITS-1:0] sample;
    logic                                    out_valid;
    logic                                    out_ready;
    logic [mmed_pkg::COL_BITS-1:0]           column;
    logic signed [mmed_pkg::SAMPLE_BITS-1:0] lowest;
    logic [mmed_pkg::HIGH_BITS-1:0]          highest;
    logic                                    past_end;

    // bench copy of the block state
    logic [mmed_pkg::COUNT_BITS-1:0]         frame_total;
    logic [mmed_pkg::COLS_BITS-1:0]          col_count;
    logic [mmed_pkg::COUNT_BITS-1:0]         frame_index;
    logic signed [mmed_pkg::SAMPLE_BITS-1:0] col_min [mmed_pkg::MAX_COLUMNS];
    logic signed [mmed_pkg::SAMPLE_BITS-1:0] col_max [mmed_pkg::MAX_COLUMNS];

    envelope_t pending_envelopes[$];
    envelope_t head;

    int  errors;
    int  n_sent;
    int  n_checked;
    int  n_past;
    int  n_writes;
    int  cycles;
    bit  tx_idle;
    bit  rx_idle;

    min_max_envelope_decimator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .sample    (sample),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .column    (column),
        .lowest    (lowest),
        .highest   (highest),
        .past_end  (past_end)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        frame_total = mmed_pkg::TOTAL_FRAMES_RESET;
        col_count   = mmed_pkg::COLUMN_COUNT_RESET;
        frame_index = '0;
        for (int i = 0; i < mmed_pkg::MAX_COLUMNS; i++)
        begin
            col_min[i] = '0;
            col_max[i] = '0;
        end
    end

    function automatic int idle_length();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 70)
            return int'($urandom_range(1, 2));
        if (r < 95)
            return int'($urandom_range(3, 8));
        return int'($urandom_range(20, 60));
    endfunction

    function automatic logic [mmed_pkg::SAMPLE_BITS-1:0] random_sample();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            1, 2:    return 16'(int'($urandom_range(0, 64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    // map one sample to its column and fold it into that column's pair
    task automatic bin_sample(input logic signed [mmed_pkg::SAMPLE_BITS-1:0] s);
        logic [mmed_pkg::COLS_BITS:0] ncols;
        logic [63:0]                  col;
        envelope_t                    e;
        if (col_count == '0)
            ncols = (mmed_pkg::COLS_BITS + 1)'(1);
        else if (col_count > mmed_pkg::COLS_BITS'(mmed_pkg::MAX_COLUMNS))
            ncols = (mmed_pkg::COLS_BITS + 1)'(mmed_pkg::MAX_COLUMNS);
        else
            ncols = {1'b0, col_count};
        e.past_end = (frame_index >= frame_total);
        if (e.past_end)
            col = 64'(ncols) - 64'd1;
        else
        begin
            col = (64'(frame_index) * 64'(ncols)) / 64'(frame_total);
            if (col >= 64'(ncols))
                col = 64'(ncols) - 64'd1;
        end
        if (s < col_min[col[mmed_pkg::COL_BITS-1:0]])
            col_min[col[mmed_pkg::COL_BITS-1:0]] = s;
        if (s > col_max[col[mmed_pkg::COL_BITS-1:0]])
            col_max[col[mmed_pkg::COL_BITS-1:0]] = s;
        e.column  = col[mmed_pkg::COL_BITS-1:0];
        e.lowest  = col_min[col[mmed_pkg::COL_BITS-1:0]];
        e.highest = col_max[col[mmed_pkg::COL_BITS-1:0]][mmed_pkg::HIGH_BITS-1:0];
        if (frame_index != '1)
            frame_index = frame_index + 1'b1;
        pending_envelopes.push_back(e);
    endtask

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_sample(input logic [mmed_pkg::SAMPLE_BITS-1:0] s);
        if (tx_idle && $urandom_range(0, 2) == 0)
        begin
            in_valid <= 1'b0;
            repeat (idle_length()) @(negedge clk);
        end
        in_valid <= 1'b1;
        sample   <= s;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bin_sample(s);
        n_sent++;
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [mmed_pkg::CFG_INDEX_BITS-1:0] idx,
                             input logic [mmed_pkg::COUNT_BITS-1:0] data, input bit hold);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == mmed_pkg::REG_TOTAL_FRAMES)
            frame_total = data;
        else
            col_count = data[mmed_pkg::COLS_BITS-1:0];
        n_writes++;
        @(negedge clk);
        if (!hold)
            cfg_valid <= 1'b0;
    endtask

    // stop sending and wait for every pending result, then let the pipe settle
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_envelopes.size() != 0)
            @(negedge clk);
        repeat (LATENCY) @(negedge clk);
    endtask

    task automatic test_default_mapping();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        send_sample(16'h7fff);
        send_sample(16'h8000);
        send_sample(16'h0000);
        send_sample(16'hffff);
        send_sample(16'h0001);
        send_sample(16'h5555);
        send_sample(16'haaaa);
    endtask

    task automatic test_register_edges();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        // zero frame count sends everything to the last column
        drain_results();
        write_reg(mmed_pkg::REG_TOTAL_FRAMES, 32'd0, 1'b0);
        send_sample(16'h7fff);
        send_sample(16'h8000);
        // column count of zero behaves as one column
        drain_results();
        write_reg(mmed_pkg::REG_TOTAL_FRAMES, frame_index + 32'd6, 1'b1);
        write_reg(mmed_pkg::REG_COLUMN_COUNT, 32'd0, 1'b0);
        send_sample(16'h1234);
        send_sample(16'hedcb);
        // oversized column count saturates
        drain_results();
        write_reg(mmed_pkg::REG_COLUMN_COUNT, 32'hffff_ffff, 1'b0);
        send_sample(16'h4000);
        send_sample(16'hc000);
        drain_results();
        write_reg(mmed_pkg::REG_TOTAL_FRAMES, 32'hffff_ffff, 1'b1);
        write_reg(mmed_pkg::REG_COLUMN_COUNT, 32'(mmed_pkg::MAX_COLUMNS), 1'b0);
        send_sample(16'h7ffe);
        send_sample(16'h8001);
        // mapping changes part way through a take, store kept
        drain_results();
        write_reg(mmed_pkg::REG_TOTAL_FRAMES, frame_index + 32'd8, 1'b1);
        write_reg(mmed_pkg::REG_COLUMN_COUNT, 32'd4, 1'b0);
        repeat (4) send_sample(random_sample());
        drain_results();
        write_reg(mmed_pkg::REG_COLUMN_COUNT, 32'd8, 1'b0);
        repeat (6) send_sample(random_sample());
    endtask

    task automatic test_random_takes(input int total);
        logic [63:0]                    span;
        logic [63:0]                    top;
        logic [mmed_pkg::COLS_BITS-1:0] cols;
        int                             kind;
        int                             length;
        while (n_sent < total)
        begin
            case ($urandom_range(0, 9))
                0:       cols = 12'd1;
                1:       cols = 12'(mmed_pkg::MAX_COLUMNS);
                2:       cols = 12'($urandom);
                3, 4:    cols = 12'($urandom_range(17, mmed_pkg::MAX_COLUMNS));
                default: cols = 12'($urandom_range(2, 16));
            endcase
            kind = int'($urandom_range(0, 9));
            if (kind == 0)
            begin
                top    = 64'($urandom);
                length = int'($urandom_range(4, 24));
            end
            else
            begin
                if (kind < 7)
                begin
                    span   = 64'($urandom_range(1, 48));
                    length = int'(span) + int'($urandom_range(0, 6));
                end
                else
                begin
                    span   = 64'($urandom_range(49, 100000));
                    length = int'($urandom_range(8, 48));
                end
                top = 64'(frame_index) + span;
                if (top > 64'hffff_ffff)
                    top = 64'hffff_ffff;
            end
            drain_results();
            tx_idle = $urandom_range(0, 3) != 0;
            rx_idle = $urandom_range(0, 3) != 0;
            write_reg(mmed_pkg::REG_TOTAL_FRAMES, top[mmed_pkg::COUNT_BITS-1:0], 1'b1);
            write_reg(mmed_pkg::REG_COLUMN_COUNT,
                      (32'($urandom) & 32'hffff_f000) | 32'(cols), 1'b0);
            repeat (length) send_sample(random_sample());
        end
    endtask

    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (rx_idle && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat (idle_length()) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_envelopes.size() == 0)
            begin
                $error("column: no sample pending, actual %0d", column);
                errors++;
            end
            else
            begin
                head = pending_envelopes.pop_front();
                n_checked++;
                if (head.past_end)
                    n_past++;
                if (column !== head.column)
                begin
                    $error("column: expected %0d, actual %0d", head.column, column);
                    errors++;
                end
                if (lowest !== head.lowest)
                begin
                    $error("lowest: expected %0d, actual %0d", head.lowest, lowest);
                    errors++;
                end
                if (highest !== head.highest)
                begin
                    $error("highest: expected %0d, actual %0d", head.highest, highest);
                    errors++;
                end
                if (past_end !== head.past_end)
                begin
                    $error("past_end: expected %0d, actual %0d", head.past_end, past_end);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycles, pending_envelopes.size());
            $display("min_max_envelope_decimator_tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = mmed_pkg::REG_TOTAL_FRAMES;
        cfg_data  = '0;
        in_valid  = 1'b0;
        sample    = '0;
        tx_idle   = 1'b0;
        rx_idle   = 1'b0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_default_mapping();
        test_register_edges();
        test_random_takes(ITEM_TARGET);
        drain_results();
        $display("%0d samples sent, %0d results checked (%0d past the end)",
                 n_sent, n_checked, n_past);
        $display("%0d register writes, %0d mismatches, %0d cycles",
                 n_writes, errors, cycles);
        if (errors == 0 && pending_envelopes.size() == 0)
            $display("min_max_envelope_decimator_tb: PASS");
        else
            $display("min_max_envelope_decimator_tb: FAIL");
        $finish;
    end

endmodule
